>>> hdl/ctbt_pkg.sv
// Types, constants and trig helpers for the camera-to-base point transform.
package ctbt_pkg;

    localparam int AXW = 23;
    localparam int P1W = 39;
    localparam int R1W = 40;
    localparam int P2W = 56;
    localparam int VW  = 57;
    localparam int RW  = 25;
    localparam int SW  = 26;
    localparam int OW  = 24;
    localparam int RND_SHIFT = 32;

    localparam logic [9:0] EANG_OFFSET = 10'd180;
    localparam logic [8:0] DEG_90  = 9'd90;
    localparam logic [8:0] DEG_180 = 9'd180;
    localparam logic [8:0] DEG_270 = 9'd270;
    localparam logic [8:0] DEG_360 = 9'd360;
    localparam logic [9:0] DEG_720 = 10'd720;
    localparam logic [6:0] QUARTER_LAST = 7'd90;

    localparam logic signed [15:0] Q14_ONE     = 16'sd16384;
    localparam logic signed [SW-1:0] OUT_MAX   = 26'sd8388607;
    localparam logic signed [SW-1:0] OUT_MIN   = -26'sd8388608;

    localparam logic [14:0] SIN_Q [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
        logic [7:0]         base_deg;
        logic [7:0]         shoulder_deg;
        logic [7:0]         elbow_deg;
        logic [7:0]         wrist_deg;
        logic signed [15:0] effector_x;
        logic signed [15:0] effector_y;
        logic signed [15:0] effector_z;
    } ctbt_req_t;

    typedef struct packed {
        logic signed [OW-1:0] base_x;
        logic signed [OW-1:0] base_y;
        logic signed [OW-1:0] base_z;
    } ctbt_rsp_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } ctbt_eff_t;

    typedef struct packed {
        logic signed [AXW-1:0] x;
        logic signed [AXW-1:0] y;
        logic signed [AXW-1:0] z;
    } ctbt_axes_t;

    typedef struct packed {
        logic signed [15:0] ce;
        logic signed [15:0] se;
        logic signed [15:0] cb;
        logic signed [15:0] sb;
    } ctbt_trig_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } ctbt_vec_t;

    function automatic logic [14:0] sin_quarter(input logic [6:0] k);
        return (k <= QUARTER_LAST) ? SIN_Q[k] : 15'd0;
    endfunction

    function automatic logic signed [15:0] sin_deg(input logic [8:0] d);
        logic [8:0]         idx;
        logic               neg;
        logic signed [15:0] mag;
        if (d <= DEG_90)
        begin
            idx = d;
            neg = 1'b0;
        end
        else if (d <= DEG_180)
        begin
            idx = DEG_180 - d;
            neg = 1'b0;
        end
        else if (d <= DEG_270)
        begin
            idx = d - DEG_180;
            neg = 1'b1;
        end
        else
        begin
            idx = DEG_360 - d;
            neg = 1'b1;
        end
        mag = signed'({1'b0, sin_quarter(idx[6:0])});
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [15:0] cos_deg(input logic [8:0] d);
        logic [9:0] t;
        t = {1'b0, d} + {1'b0, DEG_90};
        if (t >= {1'b0, DEG_360})
        begin
            t = t - {1'b0, DEG_360};
        end
        return sin_deg(t[8:0]);
    endfunction

    function automatic logic signed [AXW-1:0] scale100(input logic signed [15:0] v);
        logic signed [AXW-1:0] w;
        w = AXW'(v);
        return (w <<< 6) + (w <<< 5) + (w <<< 2);
    endfunction

endpackage

>>> hdl/ctbt_angle.sv
// Angle reduction, sine/cosine lookup and axis remap with scaling.
module ctbt_angle
    import ctbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  ctbt_req_t  in_data,
    output logic       out_valid,
    output ctbt_trig_t out_trig,
    output ctbt_axes_t out_axes,
    output ctbt_eff_t  out_eff
);

    logic       v1_reg;
    logic [8:0] eang_reg;
    logic [8:0] eang_next;
    logic [8:0] base_reg;
    ctbt_axes_t axes1_reg;
    ctbt_axes_t axes1_next;
    ctbt_eff_t  eff1_reg;
    logic [9:0] sum;

    logic       v2_reg;
    ctbt_trig_t trig_reg;
    ctbt_trig_t trig_next;
    ctbt_axes_t axes2_reg;
    ctbt_eff_t  eff2_reg;

    always_comb
    begin
        sum = 10'(in_data.shoulder_deg) + 10'(in_data.elbow_deg)
            + 10'(in_data.wrist_deg) + EANG_OFFSET;
        if (sum >= DEG_720)
        begin
            eang_next = 9'(sum - DEG_720);
        end
        else if (sum >= {1'b0, DEG_360})
        begin
            eang_next = 9'(sum - {1'b0, DEG_360});
        end
        else
        begin
            eang_next = sum[8:0];
        end
        axes1_next.x = scale100(in_data.point_z);
        axes1_next.y = -scale100(in_data.point_x);
        axes1_next.z = scale100(in_data.point_y);
    end

    always_comb
    begin
        trig_next.ce = cos_deg(eang_reg);
        trig_next.se = sin_deg(eang_reg);
        trig_next.cb = cos_deg(base_reg);
        trig_next.sb = sin_deg(base_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            eang_reg  <= eang_next;
            base_reg  <= {1'b0, in_data.base_deg};
            axes1_reg <= axes1_next;
            eff1_reg  <= '{x: in_data.effector_x, y: in_data.effector_y,
                           z: in_data.effector_z};
            trig_reg  <= trig_next;
            axes2_reg <= axes1_reg;
            eff2_reg  <= eff1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_trig  = trig_reg;
    assign out_axes  = axes2_reg;
    assign out_eff   = eff2_reg;

`ifndef SYNTHESIS
    a_eang_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> eang_reg < DEG_360)
        else $error("effector angle not reduced below 360");

    a_trig_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (trig_reg.se <= Q14_ONE) && (trig_reg.se >= -Q14_ONE)
                && (trig_reg.cb <= Q14_ONE) && (trig_reg.cb >= -Q14_ONE))
        else $error("trig value outside unit range");
`endif

endmodule

>>> hdl/ctbt_rotate.sv
// Rotation about Y by minus the effector angle, then about Z by the base angle.
module ctbt_rotate
    import ctbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  ctbt_trig_t in_trig,
    input  ctbt_axes_t in_axes,
    input  ctbt_eff_t  in_eff,
    output logic       out_valid,
    output ctbt_vec_t  out_vec,
    output ctbt_eff_t  out_eff
);

    logic                   v_r1_reg;
    logic signed [P1W-1:0]  pcx_reg;
    logic signed [P1W-1:0]  psz_reg;
    logic signed [P1W-1:0]  psx_reg;
    logic signed [P1W-1:0]  pcz_reg;
    logic signed [R1W-1:0]  y1_reg;
    logic signed [15:0]     cb1_reg;
    logic signed [15:0]     sb1_reg;
    ctbt_eff_t              eff1_reg;

    logic                   v_r2_reg;
    logic signed [R1W-1:0]  x1_reg;
    logic signed [R1W-1:0]  z1_reg;
    logic signed [R1W-1:0]  y1b_reg;
    logic signed [15:0]     cb2_reg;
    logic signed [15:0]     sb2_reg;
    ctbt_eff_t              eff2_reg;

    logic                   v_r3_reg;
    logic signed [P2W-1:0]  mcx_reg;
    logic signed [P2W-1:0]  msy_reg;
    logic signed [P2W-1:0]  msx_reg;
    logic signed [P2W-1:0]  mcy_reg;
    logic signed [R1W-1:0]  z1b_reg;
    ctbt_eff_t              eff3_reg;

    logic                   v_r4_reg;
    ctbt_vec_t              vec_reg;
    ctbt_vec_t              vec_next;
    ctbt_eff_t              eff4_reg;

    always_comb
    begin
        vec_next.x = VW'(mcx_reg) - VW'(msy_reg);
        vec_next.y = VW'(msx_reg) + VW'(mcy_reg);
        vec_next.z = {{(VW - R1W - 14){z1b_reg[R1W-1]}}, z1b_reg, 14'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_r1_reg <= 1'b0;
            v_r2_reg <= 1'b0;
            v_r3_reg <= 1'b0;
            v_r4_reg <= 1'b0;
        end
        else if (en)
        begin
            v_r1_reg <= in_valid;
            v_r2_reg <= v_r1_reg;
            v_r3_reg <= v_r2_reg;
            v_r4_reg <= v_r3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcx_reg  <= in_trig.ce * in_axes.x;
            psz_reg  <= in_trig.se * in_axes.z;
            psx_reg  <= in_trig.se * in_axes.x;
            pcz_reg  <= in_trig.ce * in_axes.z;
            y1_reg   <= {{(R1W - AXW - 14){in_axes.y[AXW-1]}}, in_axes.y, 14'b0};
            cb1_reg  <= in_trig.cb;
            sb1_reg  <= in_trig.sb;
            eff1_reg <= in_eff;

            x1_reg   <= R1W'(pcx_reg) - R1W'(psz_reg);
            z1_reg   <= R1W'(psx_reg) + R1W'(pcz_reg);
            y1b_reg  <= y1_reg;
            cb2_reg  <= cb1_reg;
            sb2_reg  <= sb1_reg;
            eff2_reg <= eff1_reg;

            mcx_reg  <= cb2_reg * x1_reg;
            msy_reg  <= sb2_reg * y1b_reg;
            msx_reg  <= sb2_reg * x1_reg;
            mcy_reg  <= cb2_reg * y1b_reg;
            z1b_reg  <= z1_reg;
            eff3_reg <= eff2_reg;

            vec_reg  <= vec_next;
            eff4_reg <= eff3_reg;
        end
    end

    assign out_valid = v_r4_reg;
    assign out_vec   = vec_reg;
    assign out_eff   = eff4_reg;

`ifndef SYNTHESIS
    a_valid_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && v_r1_reg |=> v_r2_reg)
        else $error("request lost between rotation stages");
`endif

endmodule

>>> hdl/ctbt_finish.sv
// Rounding to 1/16 cm, effector offset, saturation and output register.
module ctbt_finish
    import ctbt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      in_valid,
    input  ctbt_vec_t in_vec,
    input  ctbt_eff_t in_eff,
    output logic      out_valid,
    output ctbt_rsp_t out_data
);

    logic                  v_f1_reg;
    logic signed [RW-1:0]  rx_reg;
    logic signed [RW-1:0]  ry_reg;
    logic signed [RW-1:0]  rz_reg;
    ctbt_eff_t             eff_reg;
    ctbt_vec_t             rnd;

    logic                  v_f2_reg;
    ctbt_rsp_t             data_reg;
    ctbt_rsp_t             data_next;
    logic signed [SW-1:0]  sx;
    logic signed [SW-1:0]  sy;
    logic signed [SW-1:0]  sz;

    function automatic logic signed [OW-1:0] sat(input logic signed [SW-1:0] v);
        if (v > OUT_MAX)
        begin
            return OW'(OUT_MAX);
        end
        else if (v < OUT_MIN)
        begin
            return OW'(OUT_MIN);
        end
        return OW'(v);
    endfunction

    always_comb
    begin
        rnd.x = in_vec.x + (VW'(1) <<< (RND_SHIFT - 1));
        rnd.y = in_vec.y + (VW'(1) <<< (RND_SHIFT - 1));
        rnd.z = in_vec.z + (VW'(1) <<< (RND_SHIFT - 1));
    end

    always_comb
    begin
        sx = SW'(rx_reg) + SW'(eff_reg.x);
        sy = SW'(ry_reg) + SW'(eff_reg.y);
        sz = SW'(rz_reg) + SW'(eff_reg.z);
        data_next.base_x = sat(sx);
        data_next.base_y = sat(sy);
        data_next.base_z = sat(sz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_f1_reg <= 1'b0;
            v_f2_reg <= 1'b0;
        end
        else if (en)
        begin
            v_f1_reg <= in_valid;
            v_f2_reg <= v_f1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg   <= rnd.x[VW-1:RND_SHIFT];
            ry_reg   <= rnd.y[VW-1:RND_SHIFT];
            rz_reg   <= rnd.z[VW-1:RND_SHIFT];
            eff_reg  <= in_eff;
            data_reg <= data_next;
        end
    end

    assign out_valid = v_f2_reg;
    assign out_data  = data_reg;

`ifndef SYNTHESIS
    a_final_advance: assert property (@(posedge clk) disable iff (!rst_n)
        en && v_f1_reg |=> v_f2_reg)
        else $error("request lost at output register");
`endif

endmodule

>>> hdl/camera_to_arm_base_transform.sv
// Top level of the camera-frame to arm-base-frame point transform.
// Usage:
//   Request channel req_valid/req_ready/req_data carries one camera point
//   (Q7.8 m), the four joint angles in degrees and the effector position.
//   Response channel rsp_valid/rsp_ready/rsp_data carries the base-frame
//   point in 1/16 cm, saturated to 24 bits, one per request, in order.
//   The pipeline has 8 register stages:
//   2 angle/lookup stages, 4 rotation stages, 2 rounding/saturation stages.
//   Throughput is one request per cycle while not stalled; every stage is
//   a register and the whole pipeline moves on a single advance enable.
//   req_ready is high whenever the output register is empty or being taken.
//   When the receiver holds rsp_ready low with a response waiting, the
//   whole pipeline freezes: nothing is dropped or repeated, and requests
//   are taken again as soon as the response is taken.
//   Reset (rst_n low) clears all stage valid bits; the block holds no
//   other state and takes requests from the first edge after release.
module camera_to_arm_base_transform
    import ctbt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  ctbt_req_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output ctbt_rsp_t rsp_data
);

    logic       en;
    logic       ang_valid;
    ctbt_trig_t ang_trig;
    ctbt_axes_t ang_axes;
    ctbt_eff_t  ang_eff;
    logic       rot_valid;
    ctbt_vec_t  rot_vec;
    ctbt_eff_t  rot_eff;

    assign en        = !rsp_valid || rsp_ready;
    assign req_ready = en;

    ctbt_angle u_angle (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .in_data   (req_data),
        .out_valid (ang_valid),
        .out_trig  (ang_trig),
        .out_axes  (ang_axes),
        .out_eff   (ang_eff)
    );

    ctbt_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ang_valid),
        .in_trig   (ang_trig),
        .in_axes   (ang_axes),
        .in_eff    (ang_eff),
        .out_valid (rot_valid),
        .out_vec   (rot_vec),
        .out_eff   (rot_eff)
    );

    ctbt_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .in_vec    (rot_vec),
        .in_eff    (rot_eff),
        .out_valid (rsp_valid),
        .out_data  (rsp_data)
    );

endmodule
